FILE: hw/rtl/stable_min_priority_queue_macros.svh
// Assertion helpers used by the checker file hw/rtl/smpq_checker.sv.
`ifndef STABLE_MIN_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_MIN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SMPQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smpq assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SMPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smpq assertion failed");

`endif

FILE: hw/rtl/smpq_pkg.sv
package smpq_pkg;

    localparam int CAPACITY = 256;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);

    localparam int KEY_W    = 24;
    localparam int COORD_W  = 8;
    localparam int COST_W   = 24;
    localparam int OCC_W    = 9;
    localparam int STATUS_W = 2;

    typedef logic [AW-1:0]       t_addr;
    typedef logic [CW-1:0]       t_count;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COST_W-1:0]  cost;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef logic [1:0] t_wr_sel;
    localparam t_wr_sel WR_NONE     = 2'd0;
    localparam t_wr_sel WR_SHIFT    = 2'd1;
    localparam t_wr_sel WR_NEW_NEXT = 2'd2;
    localparam t_wr_sel WR_NEW_HERE = 2'd3;

    typedef struct packed {
        logic    cap_in;
        logic    idx_init;
        logic    idx_dec;
        t_wr_sel wr_sel;
        logic    cnt_inc;
        logic    pop_done;
        logic    res_clear;
        logic    load_out;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic key_gt;
        logic idx_zero;
    } t_sts;

    // Circular address: base plus offset, wrapped at the capacity.
    function automatic t_addr wrap_add(t_addr base, t_addr off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW+1)'(CAPACITY)) begin
            s = s - (AW+1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

endpackage

FILE: hw/rtl/smpq_in_if.sv
interface smpq_in_if;
    import smpq_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [KEY_W-1:0]   key;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COST_W-1:0]  cost;

    modport source (output valid, output operation, output key, output row, output col,
                    output cost, input ready);
    modport sink (input valid, input operation, input key, input row, input col,
                  input cost, output ready);
endinterface

FILE: hw/rtl/smpq_out_if.sv
interface smpq_out_if;
    import smpq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [COORD_W-1:0]  out_row;
    logic [COORD_W-1:0]  out_col;
    logic [COST_W-1:0]   out_cost;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output out_key, output out_row,
                    output out_col, output out_cost, output occupancy, input ready);
    modport sink (input valid, input status, input out_key, input out_row,
                  input out_col, input out_cost, input occupancy, output ready);
endinterface

FILE: hw/rtl/smpq_ram.sv
module smpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: hw/rtl/smpq_controller.sv
module smpq_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_operation,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  smpq_pkg::t_sts i_sts,
    output smpq_pkg::t_cmd o_cmd
);
    import smpq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_POPRD = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state, n_state;
    t_status    r_status, n_status;
    logic       r_out_valid, n_out_valid;
    t_cmd       cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_status    = r_status;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.cap_in    = 1'b1;
                    // read the tail for an enqueue, the head for a dequeue
                    cmd.idx_init  = (i_in_operation == OP_ENQ);
                    cmd.res_clear = 1'b1;
                    n_status      = ST_OK;
                    if (i_in_operation == OP_DEQ) begin
                        if (i_sts.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESP;
                        end else begin
                            n_state = S_POPRD;
                        end
                    end else if (i_sts.full) begin
                        n_status = ST_FULL;
                        n_state  = S_RESP;
                    end else if (i_sts.empty) begin
                        n_state = S_INS;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // walk from the tail, moving larger keys up one slot
                if (i_sts.key_gt) begin
                    cmd.wr_sel = WR_SHIFT;
                    if (i_sts.idx_zero) begin
                        n_state = S_INS;
                    end else begin
                        cmd.idx_dec = 1'b1;
                    end
                end else begin
                    cmd.wr_sel  = WR_NEW_NEXT;
                    cmd.cnt_inc = 1'b1;
                    n_state     = S_RESP;
                end
            end
            S_INS: begin
                cmd.wr_sel  = WR_NEW_HERE;
                cmd.cnt_inc = 1'b1;
                n_state     = S_RESP;
            end
            S_POPRD: begin
                cmd.pop_done = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.status   = r_status;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

FILE: hw/rtl/smpq_datapath.sv
module smpq_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [smpq_pkg::KEY_W-1:0]       i_key,
    input  logic [smpq_pkg::COORD_W-1:0]     i_row,
    input  logic [smpq_pkg::COORD_W-1:0]     i_col,
    input  logic [smpq_pkg::COST_W-1:0]      i_cost,
    input  smpq_pkg::t_cmd                   i_cmd,
    output smpq_pkg::t_sts                   o_sts,
    output logic [smpq_pkg::STATUS_W-1:0]    o_status,
    output logic [smpq_pkg::KEY_W-1:0]       o_key,
    output logic [smpq_pkg::COORD_W-1:0]     o_row,
    output logic [smpq_pkg::COORD_W-1:0]     o_col,
    output logic [smpq_pkg::COST_W-1:0]      o_cost,
    output logic [smpq_pkg::OCC_W-1:0]       o_occupancy
);
    import smpq_pkg::*;

    t_addr            r_head;
    t_count           r_count;
    t_addr            r_idx;
    t_entry           r_new;
    t_entry           r_res;
    t_entry           r_out_entry;
    t_status          r_out_status;
    logic [OCC_W-1:0] r_out_occ;

    t_count cnt_m1;
    t_addr  idx_p1;
    t_addr  rd_off;
    t_addr  rd_addr;
    t_addr  wr_addr;
    logic   wr_en;
    t_entry wr_data;
    t_entry rd_entry;
    logic [ENTRY_W-1:0] rd_raw;

    assign cnt_m1   = r_count - CW'(1);
    assign idx_p1   = r_idx + AW'(1);
    assign rd_entry = t_entry'(rd_raw);

    always_comb begin
        rd_off = '0;
        if (i_cmd.idx_init) begin
            rd_off = cnt_m1[AW-1:0];
        end else if (i_cmd.idx_dec) begin
            rd_off = r_idx - AW'(1);
        end
        rd_addr = wrap_add(r_head, rd_off);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = wrap_add(r_head, idx_p1);
        wr_data = r_new;
        case (i_cmd.wr_sel)
            WR_SHIFT: begin
                wr_en   = 1'b1;
                wr_data = rd_entry;
            end
            WR_NEW_NEXT: begin
                wr_en = 1'b1;
            end
            WR_NEW_HERE: begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(r_head, r_idx);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    smpq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_done) begin
                r_count <= cnt_m1;
                r_head  <= wrap_add(r_head, AW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_new <= '{key: i_key, row: i_row, col: i_col, cost: i_cost};
        end
        if (i_cmd.idx_init) begin
            r_idx <= (r_count == '0) ? '0 : cnt_m1[AW-1:0];
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - AW'(1);
        end
        if (i_cmd.res_clear) begin
            r_res <= '0;
        end else if (i_cmd.pop_done) begin
            r_res <= rd_entry;
        end
        if (i_cmd.load_out) begin
            r_out_entry  <= r_res;
            r_out_status <= i_cmd.status;
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count >= CW'(CAPACITY));
    assign o_sts.key_gt   = (rd_entry.key > r_new.key);
    assign o_sts.idx_zero = (r_idx == '0);

    assign o_status    = r_out_status;
    assign o_key       = r_out_entry.key;
    assign o_row       = r_out_entry.row;
    assign o_col       = r_out_entry.col;
    assign o_cost      = r_out_entry.cost;
    assign o_occupancy = r_out_occ;
endmodule

FILE: hw/rtl/stable_min_priority_queue.sv
// Bounded min-priority queue of grid points (key, row, col, cost), kept sorted in one
// circular RAM so a dequeue only advances the head. An enqueue walks from the tail,
// moving each stored entry with a larger key up one slot per cycle, so equal keys leave
// in arrival order; the walk does one RAM read and one RAM write per cycle.
// A dequeue on an empty queue or an enqueue on a full one returns status empty or full
// with zero payload. One item is in work at a time; the result sits in an output
// register so the next transaction can be accepted while it waits. No clearing pass
// after reset is needed.
module stable_min_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smpq_in_if.sink    i_in,
    smpq_out_if.source o_out
);
    import smpq_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    smpq_controller u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_operation(i_in.operation),
        .o_in_ready    (in_ready),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (out_valid),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    smpq_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (i_in.key),
        .i_row      (i_in.row),
        .i_col      (i_in.col),
        .i_cost     (i_in.cost),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_status   (o_out.status),
        .o_key      (o_out.out_key),
        .o_row      (o_out.out_row),
        .o_col      (o_out.out_col),
        .o_cost     (o_out.out_cost),
        .o_occupancy(o_out.occupancy)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
endmodule

FILE: hw/rtl/smpq_checker.sv
`include "stable_min_priority_queue_macros.svh"

module smpq_assertions (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [smpq_pkg::STATUS_W-1:0] i_out_status,
    input logic [smpq_pkg::KEY_W-1:0]    i_out_key,
    input logic [smpq_pkg::COST_W-1:0]   i_out_cost,
    input logic [smpq_pkg::OCC_W-1:0]    i_out_occupancy
);
    import smpq_pkg::*;

    logic                                 empty_res_ok;
    logic                                 full_res_ok;
    logic [STATUS_W+KEY_W+OCC_W-1:0]      out_fields;

    assign empty_res_ok = (i_out_occupancy == OCC_W'(0)) && (i_out_key == '0)
                          && (i_out_cost == '0);
    assign full_res_ok  = (i_out_occupancy == OCC_W'(CAPACITY)) && (i_out_key == '0);
    assign out_fields   = {i_out_status, i_out_key, i_out_occupancy};

    // one transaction in work at a time
    `SMPQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    `SMPQ_ASSERT_SAME(a_empty_result, i_out_valid && i_out_status == ST_EMPTY, empty_res_ok)

    `SMPQ_ASSERT_SAME(a_full_result, i_out_valid && i_out_status == ST_FULL, full_res_ok)

    `SMPQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(out_fields))
endmodule

bind stable_min_priority_queue smpq_assertions u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_status   (o_out.status),
    .i_out_key      (o_out.out_key),
    .i_out_cost     (o_out.out_cost),
    .i_out_occupancy(o_out.occupancy)
);

FILE: sim/smpq_checker.sv
module smpq_checker
    import smpq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    smpq_in_if   i_req,
    smpq_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status          status;
        t_entry           entry;
        logic [OCC_W-1:0] occupancy;
    } t_queue_result;

    // Mirror of the queue contents, index 0 holds the least key.
    t_entry        sorted_entries[$];
    t_queue_result expected_results[$];
    int            fail_count = 0;
    int            pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic t_queue_result apply_queue_op(logic op, t_entry item);
        t_queue_result r;
        int            pos;
        r        = '0;
        r.status = ST_OK;
        if (op == OP_ENQ) begin
            if (sorted_entries.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // Place after every entry with an equal or smaller key.
                pos = 0;
                while (pos < sorted_entries.size() && sorted_entries[pos].key <= item.key) begin
                    pos++;
                end
                sorted_entries.insert(pos, item);
            end
        end else if (sorted_entries.size() == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.entry = sorted_entries.pop_front();
        end
        r.occupancy = OCC_W'(sorted_entries.size());
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_entry        item;
        t_queue_result want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                item.key  = i_req.key;
                item.row  = i_req.row;
                item.col  = i_req.col;
                item.cost = i_req.cost;
                expected_results.push_back(apply_queue_op(i_req.operation, item));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction: status %0d, occupancy %0d",
                           i_rsp.status, i_rsp.occupancy);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, i_rsp.status);
                    check_field("out_key", want.entry.key, i_rsp.out_key);
                    check_field("out_row", want.entry.row, i_rsp.out_row);
                    check_field("out_col", want.entry.col, i_rsp.out_col);
                    check_field("out_cost", want.entry.cost, i_rsp.out_cost);
                    check_field("occupancy", want.occupancy, i_rsp.occupancy);
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

FILE: sim/testbench.sv
module testbench;
    import smpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LONG_HOLD   = 500;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;
    int   send_burst_left;
    logic rsp_hold_req;

    smpq_in_if  in_ch ();
    smpq_out_if out_ch ();

    stable_min_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    smpq_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (in_ch),
        .i_rsp        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mostly short gaps, a few long ones, and runs of back-to-back transactions.
    function automatic int pick_gap();
        int r;
        if (send_burst_left > 0) begin
            send_burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            send_burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_W'($urandom_range(0, 15));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                             input logic [COST_W-1:0] cost);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.key       <= key;
        in_ch.row       <= row;
        in_ch.col       <= col;
        in_ch.cost      <= cost;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic push_entry(input logic [KEY_W-1:0] key);
        send_item(OP_ENQ, key, COORD_W'($urandom), COORD_W'($urandom), COST_W'($urandom));
    endtask

    // Payload fields carry noise on a dequeue; the block must ignore them.
    task automatic pop_entry();
        send_item(OP_DEQ, KEY_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  COST_W'($urandom));
    endtask

    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    // Result side: random stalls, long ready stretches, and one long hold on request.
    initial begin
        logic rdy;
        int   span;
        out_ch.ready <= 1'b0;
        rsp_hold_req = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rsp_hold_req) begin
                rsp_hold_req = 1'b0;
                rdy  = 1'b0;
                span = LONG_HOLD;
            end else begin
                case ($urandom_range(0, 9))
                    0:       begin rdy = 1'b1; span = $urandom_range(30, 80); end
                    1:       begin rdy = 1'b0; span = $urandom_range(10, 40); end
                    2, 3:    begin rdy = 1'b0; span = $urandom_range(1, 3); end
                    default: begin rdy = 1'b1; span = $urandom_range(1, 4); end
                endcase
            end
            out_ch.ready <= rdy;
            repeat (span) @(posedge i_clk);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL stable_min_priority_queue");
        $finish;
    end

    initial begin
        send_burst_left = 0;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= OP_ENQ;
        in_ch.key       <= '0;
        in_ch.row       <= '0;
        in_ch.col       <= '0;
        in_ch.cost      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty dequeue, field extremes, equal keys in arrival order.
        pop_entry();
        send_item(OP_ENQ, '0, '0, '0, '0);
        send_item(OP_ENQ, '1, '1, '1, '1);
        send_item(OP_ENQ, KEY_W'(5), 8'h11, 8'h22, COST_W'(1));
        send_item(OP_ENQ, KEY_W'(5), 8'h33, 8'h44, COST_W'(2));
        send_item(OP_ENQ, KEY_W'(5), 8'h55, 8'h66, COST_W'(3));
        send_item(OP_ENQ, '0, 8'hAA, 8'h55, 24'h5A5A5A);
        send_item(OP_ENQ, '1, 8'h01, 8'h02, 24'hA5A5A5);
        repeat (8) pop_entry();
        send_item(OP_ENQ, KEY_W'(7), 8'h80, 8'h7F, 24'h800000);
        send_item(OP_ENQ, KEY_W'(6), 8'h7F, 8'h80, 24'h7FFFFF);
        repeat (2) pop_entry();
        wait_results_done();

        // Mixed random traffic around a small, churning queue.
        repeat (40) begin
            if ($urandom_range(0, 99) < 55) push_entry(pick_key());
            else pop_entry();
        end
        wait_results_done();

        // Fill past capacity while the result side holds off for a long stretch.
        rsp_hold_req = 1'b1;
        repeat (CAPACITY + 4) push_entry(pick_key());
        wait_results_done();

        // Drain past empty.
        repeat (CAPACITY + 4) pop_entry();
        wait_results_done();

        repeat (20) begin
            if ($urandom_range(0, 99) < 50) push_entry(pick_key());
            else pop_entry();
        end
        wait_results_done();
        repeat (300) @(posedge i_clk);
        @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS stable_min_priority_queue");
        end else begin
            $display("FAIL stable_min_priority_queue");
        end
        $finish;
    end

endmodule
